// ===== rtl/nsr_pkg.sv =====
// Shared constants, types and codes for the NFA symbol recognizer.
package nsr_pkg;

   localparam int NUM_STATES      = 32;
   localparam int RULES_PER_STATE = 8;
   localparam int STATE_W         = $clog2(NUM_STATES);
   localparam int SLOT_W          = (RULES_PER_STATE > 1) ? $clog2(RULES_PER_STATE) : 1;
   localparam int SYM_W           = 8;

   localparam logic OP_RULE   = 1'b0;
   localparam logic OP_SYMBOL = 1'b1;

   typedef struct packed {
      logic [SYM_W-1:0]   symbol;
      logic [STATE_W-1:0] target;
   } rule_entry_type;

   typedef rule_entry_type [RULES_PER_STATE-1:0] rule_row_type;

   // walker -> rule memory
   typedef struct packed {
      logic               wr_en;
      logic [STATE_W-1:0] wr_row;
      logic [SLOT_W-1:0]  wr_slot;
      rule_entry_type     wr_entry;
      logic               wr_valid;
      logic               rd_en;
      logic [STATE_W-1:0] rd_row;
   } mem_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_DONE   = 4'b1000
   } walk_state_type;

endpackage

// ===== rtl/nsr_ifs.sv =====
// Channel interfaces: request, response and register write port.
interface nsr_req_if;
   import nsr_pkg::*;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [STATE_W-1:0] rule_state;
   logic [SLOT_W-1:0]  rule_slot;
   logic [SYM_W-1:0]   rule_symbol;
   logic [STATE_W-1:0] rule_target;
   logic               rule_valid;
   logic [SYM_W-1:0]   char_in;
   logic               first_char;
   logic               last_char;

   modport source (output valid, opcode, rule_state, rule_slot, rule_symbol, rule_target,
                   rule_valid, char_in, first_char, last_char, input ready);
   modport sink   (input valid, opcode, rule_state, rule_slot, rule_symbol, rule_target,
                   rule_valid, char_in, first_char, last_char, output ready);
endinterface

interface nsr_rsp_if;
   logic valid;
   logic ready;
   logic alive;
   logic accepted;
   logic end_of_chain;

   modport source (output valid, alive, accepted, end_of_chain, input ready);
   modport sink   (input valid, alive, accepted, end_of_chain, output ready);
endinterface

interface nsr_csr_if;
   import nsr_pkg::*;
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] final_state;

   modport source (output valid, final_state, input ready);
   modport sink   (input valid, final_state, output ready);
endinterface

// ===== rtl/nsr_rule_mem.sv =====
// Rule table: one row of rules per source state, registered row read.
module nsr_rule_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  nsr_pkg::mem_cmd_type          mem_cmd,
   output nsr_pkg::rule_row_type         rd_rules,
   output logic [nsr_pkg::RULES_PER_STATE-1:0] rd_valid
);
   import nsr_pkg::*;

   rule_row_type               rule_mem [NUM_STATES];
   logic [RULES_PER_STATE-1:0] entry_valid_ff [NUM_STATES];
   rule_row_type               rd_rules_ff;
   logic [RULES_PER_STATE-1:0] rd_valid_ff;

   // symbol/target payload, no reset
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         rule_mem[mem_cmd.wr_row][mem_cmd.wr_slot] <= mem_cmd.wr_entry;
      end
      if (mem_cmd.rd_en) begin
         rd_rules_ff <= rule_mem[mem_cmd.rd_row];
      end
   end

   // per-entry valid bits, all cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_STATES; r++) begin
            entry_valid_ff[r] <= '0;
         end
         rd_valid_ff <= '0;
      end else begin
         if (mem_cmd.wr_en) begin
            entry_valid_ff[mem_cmd.wr_row][mem_cmd.wr_slot] <= mem_cmd.wr_valid;
         end
         if (mem_cmd.rd_en) begin
            rd_valid_ff <= entry_valid_ff[mem_cmd.rd_row];
         end
      end
   end

   assign rd_rules = rd_rules_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== rtl/nsr_walker.sv =====
// Sequencer: loads rules, walks all rule rows per symbol, builds the next active set.
module nsr_walker (
   input  logic                                clock,
   input  logic                                reset,
   nsr_req_if.sink                             req_ch,
   nsr_rsp_if.source                           rsp_ch,
   input  logic [nsr_pkg::STATE_W-1:0]         final_state,
   output nsr_pkg::mem_cmd_type                mem_cmd,
   input  nsr_pkg::rule_row_type               rd_rules,
   input  logic [nsr_pkg::RULES_PER_STATE-1:0] rd_valid
);
   import nsr_pkg::*;

   walk_state_type        state_ff, state_in;
   logic [STATE_W-1:0]    row_ff, row_in;
   logic [STATE_W-1:0]    proc_row_ff, proc_row_in;
   logic                  proc_en_ff, proc_en_in;
   logic [NUM_STATES-1:0] active_ff, active_in;
   logic [NUM_STATES-1:0] next_ff, next_in;
   logic [SYM_W-1:0]      char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  alive_ff, alive_in;
   logic                  accepted_ff, accepted_in;
   logic                  eoc_ff, eoc_in;
   logic [NUM_STATES-1:0] contrib;
   logic                  req_xfer;
   logic                  out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // targets fired by the row read in the previous cycle
   always_comb begin
      contrib = '0;
      if (proc_en_ff && active_ff[proc_row_ff]) begin
         for (int k = 0; k < RULES_PER_STATE; k++) begin
            if (rd_valid[k] && (rd_rules[k].symbol == char_ff)) begin
               contrib[rd_rules[k].target] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      mem_cmd.wr_en           = req_xfer && (req_ch.opcode == OP_RULE);
      mem_cmd.wr_row          = req_ch.rule_state;
      mem_cmd.wr_slot         = req_ch.rule_slot;
      mem_cmd.wr_entry.symbol = req_ch.rule_symbol;
      mem_cmd.wr_entry.target = req_ch.rule_target;
      mem_cmd.wr_valid        = req_ch.rule_valid;
      mem_cmd.rd_en           = (state_ff == ST_WALK);
      mem_cmd.rd_row          = row_ff;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      proc_row_in  = row_ff;
      proc_en_in   = (state_ff == ST_WALK);
      active_in    = active_ff;
      next_in      = proc_en_ff ? (next_ff | contrib) : next_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      alive_in     = alive_ff;
      accepted_in  = accepted_ff;
      eoc_in       = eoc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_ch.opcode == OP_SYMBOL)) begin
               if (req_ch.first_char) begin
                  active_in = NUM_STATES'(1);
               end
               next_in  = '0;
               char_in  = req_ch.char_in;
               last_in  = req_ch.last_char;
               row_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            row_in = row_ff + 1'b1;
            if (row_ff == STATE_W'(NUM_STATES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               active_in    = next_ff;
               rsp_valid_in = 1'b1;
               alive_in     = |next_ff;
               accepted_in  = next_ff[final_state];
               eoc_in       = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         proc_en_ff   <= 1'b0;
         active_ff    <= NUM_STATES'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         proc_en_ff   <= proc_en_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      proc_row_ff <= proc_row_in;
      next_ff     <= next_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
      alive_ff    <= alive_in;
      accepted_ff <= accepted_in;
      eoc_ff      <= eoc_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.alive        = alive_ff;
   assign rsp_ch.accepted     = accepted_ff;
   assign rsp_ch.end_of_chain = eoc_ff;

endmodule

// ===== rtl/nfa_symbol_recognizer_core.sv =====
// Top level of the NFA symbol recognizer: final-state register, walker and rule memory.
// A rule item writes one entry of the rule table; it gives no response. For a symbol item
// the walker reads one row of the rule memory per cycle (all rules of one source state),
// visits every one of the 32 states in order, and folds the matching targets into the
// next active set; ST_FINISH then folds in the last row, and ST_DONE loads the response
// register once the output register is free. The next item is taken once the response
// is loaded, even while it still waits on rsp_ch.ready. The rule table's valid bits are
// all cleared together by reset, so no clearing pass follows reset.
// final_state may be written on csr_ch at any time the block is idle.
module nfa_symbol_recognizer_core (
   input  logic        clock,
   input  logic        reset,
   nsr_req_if.sink     req_ch,
   nsr_rsp_if.source   rsp_ch,
   nsr_csr_if.sink     csr_ch
);
   import nsr_pkg::*;

   logic [STATE_W-1:0] final_state_ff, final_state_in;
   mem_cmd_type        mem_cmd;
   rule_row_type       rd_rules;
   logic [RULES_PER_STATE-1:0] rd_valid;

   assign csr_ch.ready   = 1'b1;
   assign final_state_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.final_state
                                                          : final_state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         final_state_ff <= STATE_W'(NUM_STATES - 1);
      end else begin
         final_state_ff <= final_state_in;
      end
   end

   nsr_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .final_state (final_state_ff),
      .mem_cmd     (mem_cmd),
      .rd_rules    (rd_rules),
      .rd_valid    (rd_valid)
   );

   nsr_rule_mem u_rule_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_cmd  (mem_cmd),
      .rd_rules (rd_rules),
      .rd_valid (rd_valid)
   );

endmodule

// ===== bench/tb_nfa_symbol_recognizer_core.sv =====
// Self-checking bench for the NFA symbol recognizer: random automata, chains, stalls.
module tb_nfa_symbol_recognizer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import nsr_pkg::*;

   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_CYCLES  = 40;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 255;
   localparam int RANDOM_PHASES = 6;

   typedef struct {
      logic               opcode;
      logic [STATE_W-1:0] rule_state;
      logic [SLOT_W-1:0]  rule_slot;
      logic [SYM_W-1:0]   rule_symbol;
      logic [STATE_W-1:0] rule_target;
      logic               rule_valid;
      logic [SYM_W-1:0]   char_in;
      logic               first_char;
      logic               last_char;
   } nsr_item_type;

   typedef struct packed {
      logic alive;
      logic accepted;
      logic end_of_chain;
   } nsr_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nsr_req_if req_ch ();
   nsr_rsp_if rsp_ch ();
   nsr_csr_if csr_ch ();

   nfa_symbol_recognizer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // transition table and active set as the bench sees them
   logic [SYM_W-1:0]      rule_sym [NUM_STATES][RULES_PER_STATE];
   logic [STATE_W-1:0]    rule_tgt [NUM_STATES][RULES_PER_STATE];
   logic                  rule_on  [NUM_STATES][RULES_PER_STATE];
   logic [NUM_STATES-1:0] live_states;
   logic [STATE_W-1:0]    final_model;

   nsr_item_type    pending_items[$];
   nsr_verdict_type expected_verdicts[$];
   nsr_item_type    drive_item;
   nsr_item_type    seen_item;
   nsr_verdict_type got_verdict;
   nsr_verdict_type want_verdict;

   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  req_gap;
   int  rsp_stall;
   int  rsp_gap;
   int  hold_asks = 0;
   int  hold_seen;
   int  hold_left;
   bit  steady = 1'b0;

   function automatic int idle_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic nsr_item_type make_rule(input int st, input int slot, input int sym,
                                              input int tgt, input bit vld);
      nsr_item_type it;
      it.opcode      = OP_RULE;
      it.rule_state  = STATE_W'(st);
      it.rule_slot   = SLOT_W'(slot);
      it.rule_symbol = SYM_W'(sym);
      it.rule_target = STATE_W'(tgt);
      it.rule_valid  = vld;
      it.char_in     = SYM_W'($urandom);
      it.first_char  = 1'($urandom_range(0, 1));
      it.last_char   = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic nsr_item_type make_sym(input int ch, input bit first, input bit last);
      nsr_item_type it;
      it.opcode      = OP_SYMBOL;
      it.rule_state  = STATE_W'($urandom);
      it.rule_slot   = SLOT_W'($urandom);
      it.rule_symbol = SYM_W'($urandom);
      it.rule_target = STATE_W'($urandom);
      it.rule_valid  = 1'($urandom_range(0, 1));
      it.char_in     = SYM_W'(ch);
      it.first_char  = first;
      it.last_char   = last;
      return it;
   endfunction

   // step the automaton by one accepted item; symbols queue one verdict
   function automatic void advance_nfa(input nsr_item_type it);
      logic [NUM_STATES-1:0] next_set;
      nsr_verdict_type v;
      if (it.opcode == OP_RULE) begin
         if (int'(it.rule_state) < NUM_STATES && int'(it.rule_slot) < RULES_PER_STATE) begin
            rule_sym[it.rule_state][it.rule_slot] = it.rule_symbol;
            rule_tgt[it.rule_state][it.rule_slot] = it.rule_target;
            rule_on[it.rule_state][it.rule_slot]  = it.rule_valid;
         end
      end else begin
         if (it.first_char) live_states = NUM_STATES'(1);
         next_set = '0;
         for (int s = 0; s < NUM_STATES; s++)
            for (int k = 0; k < RULES_PER_STATE; k++)
               if (live_states[s] && rule_on[s][k] && rule_sym[s][k] == it.char_in &&
                   int'(rule_tgt[s][k]) < NUM_STATES)
                  next_set[rule_tgt[s][k]] = 1'b1;
         live_states    = next_set;
         v.alive        = |next_set;
         v.accepted     = (int'(final_model) < NUM_STATES) ? next_set[final_model] : 1'b0;
         v.end_of_chain = it.last_char;
         expected_verdicts.push_back(v);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap      <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_gap > 0) begin
            req_gap      <= req_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            drive_item          = pending_items.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.opcode      <= drive_item.opcode;
            req_ch.rule_state  <= drive_item.rule_state;
            req_ch.rule_slot   <= drive_item.rule_slot;
            req_ch.rule_symbol <= drive_item.rule_symbol;
            req_ch.rule_target <= drive_item.rule_target;
            req_ch.rule_valid  <= drive_item.rule_valid;
            req_ch.char_in     <= drive_item.char_in;
            req_ch.first_char  <= drive_item.first_char;
            req_ch.last_char   <= drive_item.last_char;
            req_gap            <= idle_len();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response receiver, with random stalls and an occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
         hold_seen    <= 0;
         hold_left    <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_seen    <= hold_asks;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.ready && (rsp_ch.valid || $urandom_range(0, 7) == 0)) begin
         rsp_gap       = idle_len();
         rsp_ch.ready <= (rsp_gap == 0);
         rsp_stall    <= (rsp_gap > 0) ? rsp_gap - 1 : 0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor: predict on request transfers, check response transfers, watchdog
   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STATES; s++)
            for (int k = 0; k < RULES_PER_STATE; k++)
               rule_on[s][k] = 1'b0;
         live_states  = NUM_STATES'(1);
         final_model  = STATE_W'(31);
         quiet_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_verdict.alive        = rsp_ch.alive;
            got_verdict.accepted     = rsp_ch.accepted;
            got_verdict.end_of_chain = rsp_ch.end_of_chain;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected response %b", $time, got_verdict);
               mismatch_count++;
            end else begin
               want_verdict = expected_verdicts.pop_front();
               if (got_verdict.alive !== want_verdict.alive) begin
                  $display("%0t: alive expected %b actual %b", $time,
                           want_verdict.alive, got_verdict.alive);
                  mismatch_count++;
               end
               if (got_verdict.accepted !== want_verdict.accepted) begin
                  $display("%0t: accepted expected %b actual %b", $time,
                           want_verdict.accepted, got_verdict.accepted);
                  mismatch_count++;
               end
               if (got_verdict.end_of_chain !== want_verdict.end_of_chain) begin
                  $display("%0t: end_of_chain expected %b actual %b", $time,
                           want_verdict.end_of_chain, got_verdict.end_of_chain);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen_item.opcode      = req_ch.opcode;
            seen_item.rule_state  = req_ch.rule_state;
            seen_item.rule_slot   = req_ch.rule_slot;
            seen_item.rule_symbol = req_ch.rule_symbol;
            seen_item.rule_target = req_ch.rule_target;
            seen_item.rule_valid  = req_ch.rule_valid;
            seen_item.char_in     = req_ch.char_in;
            seen_item.first_char  = req_ch.first_char;
            seen_item.last_char   = req_ch.last_char;
            advance_nfa(seen_item);
         end
         if (csr_ch.valid && csr_ch.ready)
            final_model = csr_ch.final_state;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("nfa_symbol_recognizer_core test failed");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_verdicts.size() != 0);
      // a trailing rule transfer leaves no response behind
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_final(input int value);
      @(posedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.final_state <= STATE_W'(value);
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // random automaton over a small alphabet, then mostly well-formed chains
   task automatic queue_phase(input int n_items, input int fin);
      nsr_item_type     batch[$];
      logic [SYM_W-1:0] alpha [4];
      int               used;
      int               n_alpha;
      int               n_rules;
      int               base;
      int               len;
      int               ch;
      used    = (fin < 2) ? $urandom_range(2, 8) : fin + 1;
      n_alpha = $urandom_range(2, 4);
      foreach (alpha[i]) alpha[i] = SYM_W'($urandom);
      for (int s = 0; s < used; s++) begin
         n_rules = $urandom_range(1, 3);
         base    = $urandom_range(0, RULES_PER_STATE - 1);
         for (int k = 0; k < n_rules; k++)
            batch.push_back(make_rule(s, (base + k) % RULES_PER_STATE,
                                      alpha[$urandom_range(0, n_alpha - 1)],
                                      ($urandom_range(0, 9) == 0) ? int'($urandom % NUM_STATES)
                                                                  : $urandom_range(0, used - 1),
                                      $urandom_range(0, 19) != 0));
      end
      while (batch.size() < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(1, 10);
            for (int j = 0; j < len; j++) begin
               ch = ($urandom_range(0, 19) == 0) ? int'($urandom % 256)
                                                 : alpha[$urandom_range(0, n_alpha - 1)];
               batch.push_back(make_sym(ch, j == 0, j == len - 1));
            end
         end else begin
            case ($urandom_range(0, 2))
               0: batch.push_back(make_rule($urandom, $urandom, $urandom, $urandom,
                                            1'($urandom_range(0, 1))));
               1: batch.push_back(make_sym($urandom, 1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1))));
               default: batch.push_back(make_rule($urandom_range(0, used - 1), $urandom,
                                                  alpha[$urandom_range(0, n_alpha - 1)],
                                                  $urandom_range(0, used - 1),
                                                  1'($urandom_range(0, 1))));
            endcase
         end
      end
      @(negedge clock);
      foreach (batch[i]) pending_items.push_back(batch[i]);
   endtask

   initial begin
      int finals [RANDOM_PHASES];
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_RULE;
      req_ch.rule_state  = '0;
      req_ch.rule_slot   = '0;
      req_ch.rule_symbol = '0;
      req_ch.rule_target = '0;
      req_ch.rule_valid  = 1'b0;
      req_ch.char_in     = '0;
      req_ch.first_char  = 1'b0;
      req_ch.last_char   = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.final_state = '0;

      // directed part, final state left at its reset value
      pending_items.push_back(make_sym(8'h00, 1'b0, 1'b0));   // no first_char, empty table
      pending_items.push_back(make_rule(0, 0, 8'hFF, 31, 1'b1));
      pending_items.push_back(make_rule(0, 7, 8'h00, 1, 1'b1));
      pending_items.push_back(make_rule(31, 3, 8'hAA, 0, 1'b1));
      pending_items.push_back(make_rule(1, 0, 8'h55, 31, 1'b1));
      pending_items.push_back(make_sym(8'hFF, 1'b1, 1'b1));
      pending_items.push_back(make_sym(8'h00, 1'b1, 1'b0));
      pending_items.push_back(make_sym(8'h55, 1'b0, 1'b0));
      pending_items.push_back(make_sym(8'hAA, 1'b0, 1'b0));
      pending_items.push_back(make_sym(8'h77, 1'b0, 1'b0));   // chain dies
      pending_items.push_back(make_sym(8'hFF, 1'b0, 1'b1));   // stays dead
      pending_items.push_back(make_rule(0, 0, 8'hFF, 31, 1'b0));
      pending_items.push_back(make_sym(8'hFF, 1'b1, 1'b1));
      pending_items.push_back(make_rule(0, 1, 8'h00, 2, 1'b1));
      pending_items.push_back(make_rule(2, 6, 8'h55, 31, 1'b1));
      pending_items.push_back(make_sym(8'h00, 1'b1, 1'b0));   // two targets at once
      pending_items.push_back(make_sym(8'h55, 1'b0, 1'b1));
      pending_items.push_back(make_rule(31, 7, 8'hFF, 31, 1'b1));
      pending_items.push_back(make_sym(8'h00, 1'b1, 1'b0));
      pending_items.push_back(make_sym(8'h55, 1'b0, 1'b0));
      pending_items.push_back(make_sym(8'hFF, 1'b0, 1'b1));   // self loop on final

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      finals[0] = 0;
      finals[1] = 31;
      finals[2] = $urandom_range(2, 30);
      finals[3] = 1;
      finals[4] = $urandom_range(2, 30);
      finals[5] = $urandom_range(0, 31);
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_final(finals[p]);
         queue_phase(PHASE_ITEMS, finals[p]);
         if (p == 2) hold_asks++;
         steady = (p == 3);
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("nfa_symbol_recognizer_core test passed");
      else
         $display("nfa_symbol_recognizer_core test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/nsr_pkg.sv
rtl/nsr_ifs.sv
rtl/nsr_rule_mem.sv
rtl/nsr_walker.sv
rtl/nfa_symbol_recognizer_core.sv
bench/tb_nfa_symbol_recognizer_core.sv
